[design/wsd_pkg.sv]
package wsd_pkg;

  // default depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH = 2;

  // opcodes of the first header byte
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  // short length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length and key byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // result status codes
  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_EMPTY_END = 3'd1,
    ST_CLOSE     = 3'd2,
    ST_BAD_OP    = 3'd3,
    ST_MID_MSG   = 3'd4
  } status_t;

  // one classified result word on its way to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       end_flag;
    status_t    status;
  } entry_t;

endpackage

[design/wsd_front.sv]
module wsd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output wsd_pkg::entry_t push_entry
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] rem_len_r, rem_len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;
  logic        pending_r, pending_nxt;
  logic        failed_r, failed_nxt;

  logic [3:0]  opcode;
  logic [6:0]  len7;
  logic [1:0]  key_pos;
  logic [63:0] rem_dec;
  logic        len_done;

  assign opcode  = rx_byte[3:0];
  assign len7    = rx_byte[6:0];
  assign key_pos = 2'(wsd_pkg::KEY_BYTES - hdr_cnt_r);
  assign rem_dec = rem_len_r - 64'd1;

  // header parser and payload classification
  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    mask_nxt    = mask_r;
    hdr_cnt_nxt = hdr_cnt_r;
    rem_len_nxt = rem_len_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    pending_nxt = pending_r;
    failed_nxt  = failed_r;
    push        = 1'b0;
    push_entry  = '{data: 8'd0, key: 8'd0, end_flag: 1'b0, status: wsd_pkg::ST_DATA};
    len_done    = 1'b0;

    if (accept && !failed_r) begin
      case (phase_r)
        PH_HDR0: begin
          if (pending_r && opcode != wsd_pkg::OP_CONT) begin
            push              = 1'b1;
            push_entry.status = wsd_pkg::ST_MID_MSG;
            failed_nxt        = 1'b1;
          end else if (opcode == wsd_pkg::OP_CLOSE) begin
            push              = 1'b1;
            push_entry.status = wsd_pkg::ST_CLOSE;
            failed_nxt        = 1'b1;
          end else if (opcode != wsd_pkg::OP_CONT && opcode != wsd_pkg::OP_BINARY) begin
            push              = 1'b1;
            push_entry.status = wsd_pkg::ST_BAD_OP;
            failed_nxt        = 1'b1;
          end else begin
            fin_nxt   = rx_byte[7];
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_nxt = rx_byte[7];
          if (len7 == wsd_pkg::LEN_EXT16) begin
            rem_len_nxt = 64'd0;
            hdr_cnt_nxt = wsd_pkg::EXT16_BYTES;
            phase_nxt   = PH_EXTLEN;
          end else if (len7 == wsd_pkg::LEN_EXT64) begin
            rem_len_nxt = 64'd0;
            hdr_cnt_nxt = wsd_pkg::EXT64_BYTES;
            phase_nxt   = PH_EXTLEN;
          end else begin
            rem_len_nxt = {57'd0, len7};
            len_done    = 1'b1;
          end
        end
        PH_EXTLEN: begin
          rem_len_nxt = {rem_len_r[55:0], rx_byte};
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          len_done    = (hdr_cnt_nxt == 4'd0);
        end
        PH_KEY: begin
          key_nxt[8*key_pos +: 8] = rx_byte;
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_nxt == 4'd0) begin
            // key complete, header done
            key_idx_nxt = 2'd0;
            if (rem_len_r != 64'd0) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_HDR0;
              if (fin_r) begin
                pending_nxt         = 1'b0;
                push                = 1'b1;
                push_entry.end_flag = 1'b1;
                push_entry.status   = wsd_pkg::ST_EMPTY_END;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          push            = 1'b1;
          push_entry.data = rx_byte;
          push_entry.key  = key_r[8*key_idx_r +: 8];
          key_idx_nxt     = key_idx_r + 2'd1;
          rem_len_nxt     = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_HDR0;
          end
          if (rem_dec == 64'd0 && fin_r) begin
            pending_nxt         = 1'b0;
            push_entry.end_flag = 1'b1;
          end else begin
            pending_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // length known: go for the key or finish the header
      if (len_done) begin
        key_nxt = 32'd0;
        if (mask_nxt) begin
          hdr_cnt_nxt = wsd_pkg::KEY_BYTES;
          phase_nxt   = PH_KEY;
        end else begin
          key_idx_nxt = 2'd0;
          if (rem_len_nxt != 64'd0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_HDR0;
            if (fin_r) begin
              pending_nxt         = 1'b0;
              push                = 1'b1;
              push_entry.end_flag = 1'b1;
              push_entry.status   = wsd_pkg::ST_EMPTY_END;
            end
          end
        end
      end

      if (failed_nxt) begin
        phase_nxt = PH_HDR0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      fin_r     <= 1'b0;
      mask_r    <= 1'b0;
      hdr_cnt_r <= 4'd0;
      rem_len_r <= 64'd0;
      key_r     <= 32'd0;
      key_idx_r <= 2'd0;
      pending_r <= 1'b0;
      failed_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      mask_r    <= mask_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      rem_len_r <= rem_len_nxt;
      key_r     <= key_nxt;
      key_idx_r <= key_idx_nxt;
      pending_r <= pending_nxt;
      failed_r  <= failed_nxt;
    end
  end

endmodule

[design/wsd_queue.sv]
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsd_pkg::entry_t push_entry,
  input  logic            pop,
  output wsd_pkg::entry_t head_entry,
  output logic            empty,
  output logic            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_pkg::entry_t slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty      = (count_r == CW'(0));
  assign full       = (count_r == CW'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/wsd_back.sv]
module wsd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  wsd_pkg::entry_t head_entry,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_payload_byte,
  output logic            out_message_end,
  output logic [2:0]      out_status
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic [2:0] status_r;

  // load a new word when the output register is free or being taken
  assign pop = !empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= !empty;
    end
  end

  // unmask and register the result
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r   <= head_entry.data ^ head_entry.key;
      end_r    <= head_entry.end_flag;
      status_r <= head_entry.status;
    end
  end

  assign out_valid        = valid_r;
  assign out_payload_byte = byte_r;
  assign out_message_end  = end_r;
  assign out_status       = status_r;

endmodule

[design/websocket_frame_deframer_core.sv]
// websocket receive deframer, one stream byte per word on each side
// a result word is written into a queue slot and then into the output register; a queue hold or out_stall can delay it
// throughput: one byte per cycle while the queue is not full, set by the header parser state update
// a full queue between parser and output stage stalls the input
// reset: synchronous active-low rst_n clears parser state, queue and output valid
module websocket_frame_deframer_core #(
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_message_end,
  output logic [2:0] out_status
);

  logic            accept;
  logic            push;
  wsd_pkg::entry_t push_entry;
  wsd_pkg::entry_t head_entry;
  logic            pop;
  logic            empty;
  logic            full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // header parsing and classification
  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (empty),
    .full       (full)
  );

  // unmasking and output register
  wsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_entry       (head_entry),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_message_end  (out_message_end),
    .out_status       (out_status)
  );

endmodule
